// ===== design/lpg_pkg.sv =====
package lpg_pkg;

    // default coordinate width of the endpoints and pixels
    localparam int LPG_COORD_BITS = 12;

    // screen size registers
    localparam int SCREEN_BITS = 12;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;

    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 12'd320;
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd240;

    // request kinds carried on the input tuser bit
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    // depth of the queue between decode and walker
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [SCREEN_BITS-1:0] height;
        logic [SCREEN_BITS-1:0] width;
    } screen_cfg_t;

    // width of one decoded queue entry for a given coordinate width:
    // five flags, two start coordinates, a pixel count, two deltas, the end point
    function automatic int lpg_entry_width(input int coord_bits);
        return 7 * coord_bits + 6;
    endfunction

endpackage

// ===== design/lpg_front.sv =====
module lpg_front
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = LPG_COORD_BITS,
    parameter int IN_DW      = ((4 * COORD_BITS + 7) / 8) * 8,
    parameter int ENTRY_W    = lpg_entry_width(COORD_BITS)
)
(
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [IN_DW-1:0]   s_axis_tdata,
    input  logic               s_axis_tuser,
    input  logic               q_full,
    output logic               q_push,
    output logic [ENTRY_W-1:0] q_data
);

    localparam int C     = COORD_BITS;
    localparam int CNT_W = COORD_BITS + 1;

    typedef struct packed {
        logic           is_load;
        logic           axis;
        logic           vert;
        logic           x_neg;
        logic           y_neg;
        logic [C-1:0]   a0;
        logic [C-1:0]   a1;
        logic [CNT_W-1:0] cnt;
        logic [C-1:0]   dx;
        logic [C-1:0]   dy;
        logic [C-1:0]   ex;
        logic [C-1:0]   ey;
    } entry_t;

    logic [C-1:0]        x1;
    logic [C-1:0]        y1;
    logic [C-1:0]        x2;
    logic [C-1:0]        y2;
    logic signed [C:0]   dx_fwd;
    logic signed [C:0]   dx_rev;
    logic signed [C:0]   dy_fwd;
    logic signed [C:0]   dy_rev;
    logic                x_neg;
    logic                y_neg;
    logic [C-1:0]        dx;
    logic [C-1:0]        dy;
    logic                vert;
    logic                horiz;
    logic [C-1:0]        axis_min;
    entry_t              entry;

    assign x1 = s_axis_tdata[C-1:0];
    assign y1 = s_axis_tdata[2*C-1:C];
    assign x2 = s_axis_tdata[3*C-1:2*C];
    assign y2 = s_axis_tdata[4*C-1:3*C];

    // both differences at once so the magnitude is a select
    assign dx_fwd = $signed({x2[C-1], x2}) - $signed({x1[C-1], x1});
    assign dx_rev = $signed({x1[C-1], x1}) - $signed({x2[C-1], x2});
    assign dy_fwd = $signed({y2[C-1], y2}) - $signed({y1[C-1], y1});
    assign dy_rev = $signed({y1[C-1], y1}) - $signed({y2[C-1], y2});

    assign x_neg = dx_fwd[C];
    assign y_neg = dy_fwd[C];
    assign dx    = x_neg ? dx_rev[C-1:0] : dx_fwd[C-1:0];
    assign dy    = y_neg ? dy_rev[C-1:0] : dy_fwd[C-1:0];

    // a single point counts as vertical
    assign vert  = (x1 == x2);
    assign horiz = (y1 == y2);

    always_comb
    begin
        if (vert)
        begin
            axis_min = y_neg ? y2 : y1;
        end
        else
        begin
            axis_min = x_neg ? x2 : x1;
        end
    end

    always_comb
    begin
        entry.is_load = (s_axis_tuser == REQ_LOAD);
        entry.axis    = vert || horiz;
        entry.vert    = vert;
        entry.x_neg   = x_neg;
        entry.y_neg   = y_neg;
        entry.a0      = (vert || horiz) ? axis_min : x1;
        entry.a1      = vert ? x1 : y1;
        entry.cnt     = CNT_W'(vert ? dy : dx) + CNT_W'(1);
        entry.dx      = dx;
        entry.dy      = dy;
        entry.ex      = x2;
        entry.ey      = y2;
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;
    assign q_data        = entry;

endmodule

// ===== design/lpg_fifo.sv =====
module lpg_fifo
    import lpg_pkg::*;
#(
    parameter int WIDTH = lpg_entry_width(LPG_COORD_BITS),
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("pop from empty queue");
`endif

endmodule

// ===== design/lpg_back.sv =====
module lpg_back
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = LPG_COORD_BITS,
    parameter int OUT_DW     = ((2 * COORD_BITS + 7) / 8) * 8,
    parameter int ENTRY_W    = lpg_entry_width(COORD_BITS)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  screen_cfg_t        screen,
    input  logic               q_valid,
    input  logic [ENTRY_W-1:0] q_data,
    output logic               q_pop,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OUT_DW-1:0]  m_axis_tdata,  // pixel_x, pixel_y
    output logic               m_axis_tuser,  // on_screen
    output logic               m_axis_tlast   // last_pixel
);

    localparam int C     = COORD_BITS;
    localparam int CNT_W = COORD_BITS + 1;
    localparam int ERR_W = COORD_BITS + 3;
    localparam int CMP_W = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;

    typedef struct packed {
        logic           is_load;
        logic           axis;
        logic           vert;
        logic           x_neg;
        logic           y_neg;
        logic [C-1:0]   a0;
        logic [C-1:0]   a1;
        logic [CNT_W-1:0] cnt;
        logic [C-1:0]   dx;
        logic [C-1:0]   dy;
        logic [C-1:0]   ex;
        logic [C-1:0]   ey;
    } entry_t;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_AXIS,
        MODE_BRES
    } mode_t;

    entry_t                    e;

    mode_t                     mode_reg,      mode_next;
    logic [C-1:0]              maj_pos_reg,   maj_pos_next;
    logic [C-1:0]              min_pos_reg,   min_pos_next;
    logic signed [ERR_W-1:0]   err_reg,       err_next;
    logic signed [ERR_W-1:0]   inc_a_reg,     inc_a_next;
    logic signed [ERR_W-1:0]   inc_b_reg,     inc_b_next;
    logic                      maj_neg_reg,   maj_neg_next;
    logic                      min_neg_reg,   min_neg_next;
    logic                      steep_reg,     steep_next;
    logic [CNT_W-1:0]          steps_reg,     steps_next;
    logic [C-1:0]              fin_x_reg,     fin_x_next;
    logic [C-1:0]              fin_y_reg,     fin_y_next;
    logic                      out_valid_reg, out_valid_next;
    logic [C-1:0]              out_x_reg,     out_x_next;
    logic [C-1:0]              out_y_reg,     out_y_next;
    logic                      out_on_reg,    out_on_next;
    logic                      out_last_reg,  out_last_next;

    logic                      emit;
    logic                      emit_last;
    logic [C-1:0]              emit_x;
    logic [C-1:0]              emit_y;
    logic                      emit_on;
    logic [C-1:0]              cur_x;
    logic [C-1:0]              cur_y;
    logic                      load_steep;
    logic signed [ERR_W-1:0]   two_dx;
    logic signed [ERR_W-1:0]   two_dy;
    logic [C-1:0]              maj_step;
    logic [C-1:0]              min_step;
    logic                      err_pos;

    assign e = q_data;

    // a step while idle and any load never touch the output slot
    assign q_pop = q_valid && (e.is_load || (mode_reg == MODE_IDLE) || !out_valid_reg ||
                   m_axis_tready);
    assign emit  = q_pop && !e.is_load && (mode_reg != MODE_IDLE);

    assign cur_x = steep_reg ? min_pos_reg : maj_pos_reg;
    assign cur_y = steep_reg ? maj_pos_reg : min_pos_reg;

    always_comb
    begin
        emit_x    = cur_x;
        emit_y    = cur_y;
        emit_last = 1'b0;
        if (mode_reg == MODE_AXIS)
        begin
            emit_last = (steps_reg == CNT_W'(1));
        end
        else if (steps_reg == '0)
        begin
            emit_x    = fin_x_reg;
            emit_y    = fin_y_reg;
            emit_last = 1'b1;
        end
    end

    // clip test against the screen size registers
    assign emit_on = !emit_x[C-1] && (CMP_W'(emit_x) < CMP_W'(screen.width)) &&
                     !emit_y[C-1] && (CMP_W'(emit_y) < CMP_W'(screen.height));

    assign load_steep = (e.dy > e.dx);
    assign two_dx     = $signed(ERR_W'({e.dx, 1'b0}));
    assign two_dy     = $signed(ERR_W'({e.dy, 1'b0}));

    assign maj_step = maj_neg_reg ? {C{1'b1}} : C'(1);
    assign min_step = min_neg_reg ? {C{1'b1}} : C'(1);
    assign err_pos  = !err_reg[ERR_W-1] && (err_reg != '0);

    always_comb
    begin
        mode_next      = mode_reg;
        maj_pos_next   = maj_pos_reg;
        min_pos_next   = min_pos_reg;
        err_next       = err_reg;
        inc_a_next     = inc_a_reg;
        inc_b_next     = inc_b_reg;
        maj_neg_next   = maj_neg_reg;
        min_neg_next   = min_neg_reg;
        steep_next     = steep_reg;
        steps_next     = steps_reg;
        fin_x_next     = fin_x_reg;
        fin_y_next     = fin_y_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_on_next    = out_on_reg;
        out_last_next  = out_last_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop && e.is_load)
        begin
            fin_x_next = e.ex;
            fin_y_next = e.ey;
            if (e.axis)
            begin
                mode_next    = MODE_AXIS;
                steep_next   = e.vert;
                maj_pos_next = e.a0;
                min_pos_next = e.a1;
                steps_next   = e.cnt;
            end
            else if (load_steep)
            begin
                mode_next    = MODE_BRES;
                steep_next   = 1'b1;
                maj_pos_next = e.a1;
                min_pos_next = e.a0;
                maj_neg_next = e.y_neg;
                min_neg_next = e.x_neg;
                err_next     = two_dx - $signed(ERR_W'(e.dy));
                inc_a_next   = two_dx;
                inc_b_next   = two_dx - two_dy;
                steps_next   = CNT_W'(e.dy);
            end
            else
            begin
                mode_next    = MODE_BRES;
                steep_next   = 1'b0;
                maj_pos_next = e.a0;
                min_pos_next = e.a1;
                maj_neg_next = e.x_neg;
                min_neg_next = e.y_neg;
                err_next     = two_dy - $signed(ERR_W'(e.dx));
                inc_a_next   = two_dy;
                inc_b_next   = two_dy - two_dx;
                steps_next   = CNT_W'(e.dx);
            end
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            out_x_next     = emit_x;
            out_y_next     = emit_y;
            out_on_next    = emit_on;
            out_last_next  = emit_last;
            if (emit_last)
            begin
                mode_next = MODE_IDLE;
            end
            if (mode_reg == MODE_AXIS)
            begin
                maj_pos_next = maj_pos_reg + C'(1);
                steps_next   = steps_reg - CNT_W'(1);
            end
            else if (!emit_last)
            begin
                maj_pos_next = maj_pos_reg + maj_step;
                steps_next   = steps_reg - CNT_W'(1);
                if (err_pos)
                begin
                    min_pos_next = min_pos_reg + min_step;
                    err_next     = err_reg + inc_b_reg;
                end
                else
                begin
                    err_next = err_reg + inc_a_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            maj_pos_reg   <= '0;
            min_pos_reg   <= '0;
            err_reg       <= '0;
            inc_a_reg     <= '0;
            inc_b_reg     <= '0;
            maj_neg_reg   <= 1'b0;
            min_neg_reg   <= 1'b0;
            steep_reg     <= 1'b0;
            steps_reg     <= '0;
            fin_x_reg     <= '0;
            fin_y_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_on_reg    <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            maj_pos_reg   <= maj_pos_next;
            min_pos_reg   <= min_pos_next;
            err_reg       <= err_next;
            inc_a_reg     <= inc_a_next;
            inc_b_reg     <= inc_b_next;
            maj_neg_reg   <= maj_neg_next;
            min_neg_reg   <= min_neg_next;
            steep_reg     <= steep_next;
            steps_reg     <= steps_next;
            fin_x_reg     <= fin_x_next;
            fin_y_reg     <= fin_y_next;
            out_valid_reg <= out_valid_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_on_reg    <= out_on_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DW'({out_y_reg, out_x_reg});
    assign m_axis_tuser  = out_on_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    a_axis_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_AXIS) |-> (steps_reg != '0))
        else $error("axis line active with no pixels left");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_last) |=> (mode_reg == MODE_IDLE))
        else $error("line still active after its last pixel");

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || m_axis_tready))
        else $error("pixel written over a pending one");
`endif

endmodule

// ===== design/line_pixel_generator_unit.sv =====
// line pixel generator: a load request (tuser 0) takes a line from the start
// point to the end point in tdata and gives no pixel; every later step request
// (tuser 1) gives the next pixel of that line, with tuser flagging on screen
// and tlast marking the final pixel. axis lines run from the smaller to the
// larger coordinate inclusive, other lines walk bresenham on the major axis and
// end with the exact end point. steps while no line is active are swallowed,
// and a load in the middle of a line drops the old one. while the output is
// not stalled, one request is taken per cycle and one pixel leaves per cycle,
// set by the walker's single error add and compare; a request passes from
// decode into a two-entry queue, then through the walker into its output register.
// the screen size registers may only be written while no request is pending.
module line_pixel_generator_unit
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = LPG_COORD_BITS
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0]                 cfg_index,
    input  logic [SCREEN_BITS-1:0]                  cfg_wdata,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // start_x, start_y, end_x, end_y
    input  logic [((4 * COORD_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    // req_type
    input  logic                                    s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // pixel_x, pixel_y
    output logic [((2 * COORD_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
    // on_screen
    output logic                                    m_axis_tuser,
    // last_pixel
    output logic                                    m_axis_tlast
);

    localparam int IN_DW   = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DW  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int ENTRY_W = lpg_entry_width(COORD_BITS);

    // screen size registers, only used by the clip test
    screen_cfg_t          screen_reg;

    // decode side of the queue
    logic                 q_push;
    logic                 q_full;
    logic [ENTRY_W-1:0]   q_push_data;

    // walker side of the queue
    logic                 q_pop;
    logic                 q_valid;
    logic [ENTRY_W-1:0]   q_pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_reg.width  <= SCREEN_WIDTH_RESET;
            screen_reg.height <= SCREEN_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  screen_reg.width  <= cfg_wdata;
                REG_SCREEN_HEIGHT: screen_reg.height <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // classify each request and precompute deltas, signs and axis spans
    lpg_front #(
        .COORD_BITS (COORD_BITS),
        .IN_DW      (IN_DW),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_push_data)
    );

    // short queue so decode keeps taking requests while the output stalls
    lpg_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_pop_data)
    );

    // line walker with the registered output slot
    lpg_back #(
        .COORD_BITS (COORD_BITS),
        .OUT_DW     (OUT_DW),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .screen        (screen_reg),
        .q_valid       (q_valid),
        .q_data        (q_pop_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
